// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define BIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bia assertion failed");

// Next-cycle implication under reset.
`define BIA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bia assertion failed");

`endif

// ===== hw/rtl/bia_pkg.sv =====
// Package of the bitmap identifier allocator: sizes, codes, types.
// No dependencies.
package bia_pkg;

  localparam int RANGE_IDS   = 2048;
  localparam int WORD_BITS   = 64;
  localparam int MAP_WORDS   = (RANGE_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int POS_W       = WORD_IDX_W + BIT_IDX_W;
  localparam int CNT_W       = $clog2(RANGE_IDS + 1);
  localparam int ID_W        = 64;
  localparam int BASE_W      = 63;
  localparam int STATUS_W    = 2;
  localparam int USED_W      = 12;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WORD_IDX_W-1:0] widx_t;
  typedef logic [BIT_IDX_W-1:0]  bidx_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY
  } state_t;

  typedef struct packed {
    logic  en;
    widx_t idx;
    word_t data;
  } map_wr_t;

  typedef struct packed {
    logic  en;
    widx_t idx;
    logic  full;
  } sum_upd_t;

endpackage

// ===== hw/rtl/bia_if.sv =====
// Valid/ready channels of the allocator: request items and result items.
// Depends on bia_pkg.
interface bia_in_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [bia_pkg::ID_W-1:0] rel_id;

  modport source (output valid, output operation, output rel_id, input ready);
  modport sink   (input valid, input operation, input rel_id, output ready);
endinterface

interface bia_out_if;
  logic                         valid;
  logic                         ready;
  logic [bia_pkg::ID_W-1:0]     granted_id;
  logic [bia_pkg::STATUS_W-1:0] status;
  logic [bia_pkg::USED_W-1:0]   used_count;

  modport source (output valid, output granted_id, output status, output used_count,
                  input ready);
  modport sink   (input valid, input granted_id, input status, input used_count,
                  output ready);
endinterface

// ===== hw/rtl/bia_map_ram.sv =====
// Used-map word memory, one write and one registered read per cycle.
// Per-word valid bits make unwritten words read as zero. Depends on bia_pkg.
module bia_map_ram (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  bia_pkg::widx_t   rd_idx,
  input  bia_pkg::map_wr_t wr,
  output bia_pkg::word_t   rd_data
);

  bia_pkg::word_t                    mem [bia_pkg::MAP_WORDS];
  logic [bia_pkg::MAP_WORDS-1:0]     vld_r;
  bia_pkg::word_t                    rd_raw_r;
  logic                              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

// ===== hw/rtl/bia_summary.sv =====
// Per-word full flags of the used map and the first word with a free bit.
// Depends on bia_pkg.
module bia_summary (
  input  logic              clk,
  input  logic              rst_n,
  input  bia_pkg::sum_upd_t upd,
  output bia_pkg::widx_t    free_idx,
  output logic              free_any
);

  logic [bia_pkg::MAP_WORDS-1:0] full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
    end else if (upd.en) begin
      full_r[upd.idx] <= upd.full;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = bia_pkg::MAP_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        free_idx = bia_pkg::WORD_IDX_W'(i);
      end
    end
  end

  assign free_any = ~&full_r;

endmodule

// ===== hw/rtl/bitmap_id_allocator_core.sv =====
// Bitmap identifier allocator: used-map memory, word summary and control.
// Depends on bia_pkg, bia_if, bia_map_ram, bia_summary.
//
// Usage:
//   in_ch carries request items: operation 0 allocates the lowest free
//   identifier, 1 releases rel_id. out_ch returns one result item per
//   request: granted_id, status (ok, map full, out of range) and used_count.
//   cfg_we/cfg_wdata write id_base; write it only while the block is idle.
//   Each item passes through accept, read of the map word from the
//   registered-read memory, then find-first-zero, write-back and result capture.
//   The result item is registered when the modify step completes.
//   Requests are taken one at a time; the next is accepted while a finished
//   result still waits in the output register.
//   If out_ch stalls with a result waiting, the next item holds in its
//   modify step, leaving the map untouched until the result is taken.
//   Reset (rst_n low, synchronous) frees every identifier, clears the count
//   and sets id_base to 1; no clearing pass is needed.
module bitmap_id_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  bia_in_if.sink                     in_ch,
  bia_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [bia_pkg::BASE_W-1:0] cfg_wdata
);

  localparam logic [bia_pkg::POS_W:0] POS_LIM = (bia_pkg::POS_W + 1)'(bia_pkg::RANGE_IDS);
  localparam bia_pkg::cnt_t           CNT_MAX = bia_pkg::CNT_W'(bia_pkg::RANGE_IDS);

  bia_pkg::state_t               state_r, state_nxt;
  logic [bia_pkg::BASE_W-1:0]    base_r;
  logic                          op_r;
  bia_pkg::widx_t                widx_r;
  bia_pkg::bidx_t                bit_r;
  logic                          oor_r;
  logic                          any_r;
  bia_pkg::cnt_t                 count_r;
  logic                          out_valid_r;
  logic [bia_pkg::ID_W-1:0]      granted_r;
  logic [bia_pkg::STATUS_W-1:0]  status_r;
  logic [bia_pkg::USED_W-1:0]    used_r;

  logic                          accept;
  logic                          rd_en;
  logic                          proceed;
  bia_pkg::word_t                rd_word;
  bia_pkg::widx_t                free_idx;
  logic                          free_any;
  logic [bia_pkg::ID_W-1:0]      diff;
  logic                          rel_oor;
  bia_pkg::bidx_t                lz;
  bia_pkg::pos_t                 pos;
  logic                          found;
  bia_pkg::word_t                new_word;
  logic                          do_write;
  bia_pkg::map_wr_t              map_wr;
  bia_pkg::sum_upd_t             sum_upd;
  bia_pkg::cnt_t                 count_new;

  bia_map_ram u_map_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_idx  (widx_r),
    .wr      (map_wr),
    .rd_data (rd_word)
  );

  bia_summary u_summary (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (sum_upd),
    .free_idx (free_idx),
    .free_any (free_any)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bia_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = bia_pkg::ST_READ;
        end
      end
      bia_pkg::ST_READ: begin
        state_nxt = bia_pkg::ST_MODIFY;
      end
      bia_pkg::ST_MODIFY: begin
        if (proceed) begin
          state_nxt = bia_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bia_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    proceed     = 1'b0;
    unique case (state_r)
      bia_pkg::ST_IDLE:   in_ch.ready = rst_n;
      bia_pkg::ST_READ:   rd_en       = 1'b1;
      bia_pkg::ST_MODIFY: proceed     = !out_valid_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign accept  = in_ch.valid && in_ch.ready;
  assign diff    = in_ch.rel_id - bia_pkg::ID_W'(base_r);
  assign rel_oor = (in_ch.rel_id < bia_pkg::ID_W'(base_r)) ||
                   (diff >= bia_pkg::ID_W'(bia_pkg::RANGE_IDS));

  always_comb begin
    lz = '0;
    for (int i = bia_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_word[i]) begin
        lz = bia_pkg::BIT_IDX_W'(i);
      end
    end
  end

  assign pos   = {widx_r, lz};
  assign found = any_r && !(&rd_word) && ({1'b0, pos} < POS_LIM);

  always_comb begin
    new_word  = rd_word;
    do_write  = 1'b0;
    count_new = count_r;
    if (op_r == bia_pkg::OP_ALLOC) begin
      new_word[lz] = 1'b1;
      do_write     = found;
      if (found && count_r < CNT_MAX) begin
        count_new = count_r + 1'b1;
      end
    end else begin
      new_word[bit_r] = 1'b0;
      do_write        = !oor_r;
      if (!oor_r && count_r != '0) begin
        count_new = count_r - 1'b1;
      end
    end
  end

  assign map_wr.en    = proceed && do_write;
  assign map_wr.idx   = widx_r;
  assign map_wr.data  = new_word;
  assign sum_upd.en   = proceed && do_write;
  assign sum_upd.idx  = widx_r;
  assign sum_upd.full = &new_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= bia_pkg::BASE_RESET;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bia_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (proceed) begin
        count_r     <= count_new;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.operation;
      oor_r <= rel_oor;
      any_r <= free_any;
      bit_r <= diff[bia_pkg::BIT_IDX_W-1:0];
      if (in_ch.operation == bia_pkg::OP_ALLOC) begin
        widx_r <= free_idx;
      end else begin
        widx_r <= diff[bia_pkg::POS_W-1:bia_pkg::BIT_IDX_W];
      end
    end
    if (proceed) begin
      used_r <= bia_pkg::USED_W'(count_new);
      if (op_r == bia_pkg::OP_ALLOC) begin
        granted_r <= found ? (bia_pkg::ID_W'(base_r) + bia_pkg::ID_W'(pos)) : '0;
        status_r  <= found ? bia_pkg::STATUS_OK : bia_pkg::STATUS_FULL;
      end else begin
        granted_r <= '0;
        status_r  <= oor_r ? bia_pkg::STATUS_RANGE : bia_pkg::STATUS_OK;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.granted_id = granted_r;
  assign out_ch.status     = status_r;
  assign out_ch.used_count = used_r;

endmodule

// ===== hw/rtl/bia_checker.sv =====
// Port-level checks of the allocator, bound to the top level.
// Depends on bia_pkg, the shared assertion macro header and bitmap_id_allocator_core.
`include "assert_macros.svh"

module bia_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bia_pkg::ID_W-1:0]     granted_id,
  input logic [bia_pkg::STATUS_W-1:0] status,
  input logic [bia_pkg::USED_W-1:0]   used_count
);

  logic [bia_pkg::ID_W+bia_pkg::STATUS_W+bia_pkg::USED_W-1:0] out_data;
  logic                                                       out_stall;
  logic                                                       status_legal;
  logic                                                       status_fail;

  assign out_data     = {granted_id, status, used_count};
  assign out_stall    = out_valid && !out_ready;
  assign status_legal = (status == bia_pkg::STATUS_OK) || (status == bia_pkg::STATUS_FULL) ||
                        (status == bia_pkg::STATUS_RANGE);
  assign status_fail  = (status != bia_pkg::STATUS_OK);

  `BIA_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))
  `BIA_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
  `BIA_ASSERT_IMP(a_status_legal, clk, rst_n, out_valid, status_legal)
  `BIA_ASSERT_IMP(a_fail_no_id, clk, rst_n, out_valid && status_fail, granted_id == '0)

endmodule

bind bitmap_id_allocator_core bia_checker u_bia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .granted_id (out_ch.granted_id),
  .status     (out_ch.status),
  .used_count (out_ch.used_count)
);
